// ----- rtl/bia_pkg.sv -----
`default_nettype none

package bia_pkg;

    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;
    localparam int ID_W      = 11;
    localparam int RID_W     = 32;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [RID_W-1:0] release_id;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0] granted_id;
        logic            map_full;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLR  = 3'b001,
        ST_IDLE = 3'b010,
        ST_UPD  = 3'b100
    } t_state;

    typedef struct packed {
        logic clr;
        logic accept;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_alloc;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/bitmap_id_allocator_core.sv -----
// bitmap id allocator
// input channel (i_valid/o_ready, i_item): mode 0 asks for the lowest free id,
// mode 1 frees release_id; id 0 or ids above 32*MAP_WORDS are dropped quietly
// output channel (o_valid/i_ready, o_item): one item per allocate request with
// granted_id (1 and up) or granted_id 0 with map_full set; releases give none
// the accept cycle presents the word address to the bitmap ram (lowest
// nonempty word from a per-word flag vector, or the word of the released id);
// the next cycle finds the lowest set bit in the read word for an allocate or
// sets the released bit, writes the word back and, for an allocate, loads the
// output register; o_ready is low during this single-port-write ram
// read/modify/write, so no new item is taken until the last one is done
// output appears the cycle after the update; after reset a clearing pass
// writes all-ones to the map with o_ready low; every id is free afterwards
// a stalled receiver holds the result in the output register; the next item is
// still accepted and released ids are processed, while a new allocate waits in
// its update cycle until the output register is free
`default_nettype none

module bitmap_id_allocator_core
    import bia_pkg::*;
#(
    parameter int MAP_WORDS = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_item,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_item
);

    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    t_cmd cmd;
    t_sts sts;

    bia_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    bia_dp #(
        .MAP_WORDS (MAP_WORDS),
        .AW        (AW)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_ready (i_ready),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

endmodule

`default_nettype wire

// ----- rtl/bia_ram.sv -----
`default_nettype none

module bia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/bia_ctrl.sv -----
`default_nettype none

module bia_ctrl
    import bia_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_sts i_sts,
    output logic      o_ready,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            ST_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
                if (i_valid) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                if (!i_sts.is_alloc || i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bia_dp.sv -----
`default_nettype none

module bia_dp
    import bia_pkg::*;
#(
    parameter int MAP_WORDS = 32,
    parameter int AW        = 5
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in_item i_item,
    input  wire logic     i_ready,
    input  wire t_cmd     i_cmd,
    output t_sts          o_sts,
    output logic          o_valid,
    output t_out_item     o_item
);

    function automatic logic [AW-1:0] ffs_word(input logic [MAP_WORDS-1:0] v);
        logic [AW-1:0] idx;
        idx = '0;
        for (int k = MAP_WORDS - 1; k >= 0; k--) begin
            if (v[k]) begin
                idx = AW'(k);
            end
        end
        return idx;
    endfunction

    function automatic logic [BIT_W-1:0] ffs_bit(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] w;
        logic [BIT_W-1:0]     pos;
        w   = v;
        pos = '0;
        if (w[15:0] == '0) begin
            w      = w >> 16;
            pos[4] = 1'b1;
        end
        if (w[7:0] == '0) begin
            w      = w >> 8;
            pos[3] = 1'b1;
        end
        if (w[3:0] == '0) begin
            w      = w >> 4;
            pos[2] = 1'b1;
        end
        if (w[1:0] == '0) begin
            w      = w >> 2;
            pos[1] = 1'b1;
        end
        if (w[0] == 1'b0) begin
            pos[0] = 1'b1;
        end
        return pos;
    endfunction

    logic [MAP_WORDS-1:0] r_ne;
    logic [AW-1:0]        r_clr_cnt;
    logic                 r_mode;
    logic [AW-1:0]        r_addr;
    logic [BIT_W-1:0]     r_bit;
    logic                 r_rel_ok;
    logic                 r_full;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [RID_W-1:0]       rel_pos;
    logic [RID_W-BIT_W-1:0] rel_word;
    logic                   rel_ok;
    logic [AW-1:0]          acc_addr;
    logic [AW-1:0]          rd_addr;
    logic [WORD_BITS-1:0]   rd_data;
    logic [BIT_W-1:0]       alloc_bit;
    logic [WORD_BITS-1:0]   new_word;
    logic                   upd_wr;
    logic                   ram_wr;
    logic [AW-1:0]          ram_wr_addr;
    logic [WORD_BITS-1:0]   ram_wr_data;
    logic [AW+BIT_W:0]      id_sum;

    assign rel_pos  = i_item.release_id - RID_W'(1);
    assign rel_word = rel_pos[RID_W-1:BIT_W];
    assign rel_ok   = (i_item.release_id != '0)
                    && (rel_word < (RID_W-BIT_W)'(MAP_WORDS));
    assign acc_addr = (i_item.mode == MODE_ALLOC) ? ffs_word(r_ne) : rel_word[AW-1:0];
    assign rd_addr  = i_cmd.accept ? acc_addr : r_addr;

    assign alloc_bit = ffs_bit(rd_data);
    assign new_word  = (r_mode == MODE_ALLOC)
                     ? (rd_data & ~(WORD_BITS'(1) << alloc_bit))
                     : (rd_data | (WORD_BITS'(1) << r_bit));
    assign upd_wr    = i_cmd.commit && ((r_mode == MODE_ALLOC) ? !r_full : r_rel_ok);
    assign id_sum    = {1'b0, r_addr, alloc_bit} + (AW+BIT_W+1)'(1);

    assign ram_wr      = i_cmd.clr || upd_wr;
    assign ram_wr_addr = i_cmd.clr ? r_clr_cnt : r_addr;
    assign ram_wr_data = i_cmd.clr ? '1 : new_word;

    bia_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ne        <= '1;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            if (upd_wr) begin
                r_ne[r_addr] <= |new_word;
            end
            if (i_cmd.commit && r_mode == MODE_ALLOC) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode   <= i_item.mode;
            r_addr   <= acc_addr;
            r_bit    <= rel_pos[BIT_W-1:0];
            r_rel_ok <= rel_ok;
            r_full   <= ~|r_ne;
        end
        if (i_cmd.commit && r_mode == MODE_ALLOC) begin
            r_out.granted_id <= r_full ? '0 : ID_W'(id_sum);
            r_out.map_full   <= r_full;
        end
    end

    assign o_sts.clr_last = (r_clr_cnt == AW'(MAP_WORDS - 1));
    assign o_sts.is_alloc = (r_mode == MODE_ALLOC);
    assign o_sts.out_free = !r_out_valid || i_ready;
    assign o_valid        = r_out_valid;
    assign o_item         = r_out;

endmodule

`default_nettype wire

// ----- rtl/bia_checker.sv -----
`default_nettype none

module bia_checker
    import bia_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_valid,
    input wire logic      o_ready,
    input wire logic      o_valid,
    input wire logic      i_ready,
    input wire t_out_item o_item
);

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_full_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.map_full |-> o_item.granted_id == '0)
        else $error("full result with nonzero id");

    a_grant_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item.map_full |-> o_item.granted_id != '0)
        else $error("granted id zero without full");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("item accepted while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("stalled item changed");

endmodule

bind bitmap_id_allocator_core bia_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_item  (o_item)
);

`default_nettype wire

// ----- dv/tb_bitmap_id_allocator_core.sv -----
`default_nettype none

module tb_bitmap_id_allocator_core;
    import bia_pkg::*;

    localparam int MAP_WORDS = 32;
    localparam int CAPACITY  = WORD_BITS * MAP_WORDS;
    localparam int N_RANDOM  = 1330;
    localparam int N_FILL    = 1150;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_item;

    t_in_item  request_q[$];
    t_out_item grant_q[$];
    logic [WORD_BITS-1:0] free_words[MAP_WORDS];

    int n_items;
    int n_acc;
    int n_err;
    logic in_taken;

    bitmap_id_allocator_core #(
        .MAP_WORDS(MAP_WORDS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_item (i_item),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_item (o_item)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic void queue_alloc();
        t_in_item r;
        r.mode = MODE_ALLOC;
        r.release_id = $urandom;
        request_q.push_back(r);
    endfunction

    function automatic void queue_release(input logic [RID_W-1:0] id);
        t_in_item r;
        r.mode = MODE_RELEASE;
        r.release_id = id;
        request_q.push_back(r);
    endfunction

    function automatic logic [RID_W-1:0] pick_release_id();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
            return $urandom_range(1, CAPACITY);
        end else if (sel < 82) begin
            return $urandom_range(1, 64);
        end else if (sel < 87) begin
            return '0;
        end else if (sel < 94) begin
            return $urandom;
        end else if (sel < 98) begin
            return $urandom_range(CAPACITY + 1, CAPACITY + 40);
        end else begin
            return '1;
        end
    endfunction

    // free map shadow: releases set a bit, allocates take the lowest set bit
    task automatic apply_request(input t_in_item req);
        logic [RID_W-1:0] pos;
        t_out_item res;
        bit found;
        if (req.mode == MODE_RELEASE) begin
            if (req.release_id != '0 && req.release_id <= CAPACITY) begin
                pos = req.release_id - 1;
                free_words[pos >> 5][pos[BIT_W-1:0]] = 1'b1;
            end
        end else begin
            found = 1'b0;
            res.granted_id = '0;
            res.map_full = 1'b1;
            for (int w = 0; w < MAP_WORDS && !found; w++) begin
                for (int b = 0; b < WORD_BITS && !found; b++) begin
                    if (free_words[w][b]) begin
                        free_words[w][b] = 1'b0;
                        res.granted_id = ID_W'(w * WORD_BITS + b + 1);
                        res.map_full = 1'b0;
                        found = 1'b1;
                    end
                end
            end
            grant_q.push_back(res);
        end
    endtask

    // result check first, then prediction of the item taken at this edge
    always @(posedge i_clk) begin : check_and_predict
        t_out_item exp_res;
        if (o_valid && i_ready) begin
            if (grant_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) begin
                    $display("unexpected result: granted_id %0d map_full %0b",
                        o_item.granted_id, o_item.map_full);
                end
            end else begin
                exp_res = grant_q.pop_front();
                if (o_item.granted_id !== exp_res.granted_id
                        || o_item.map_full !== exp_res.map_full) begin
                    n_err++;
                    if (n_err <= 10) begin
                        $display("mismatch: granted_id exp %0d got %0d, map_full exp %0b got %0b",
                            exp_res.granted_id, o_item.granted_id,
                            exp_res.map_full, o_item.map_full);
                    end
                end
            end
        end
        in_taken <= i_valid && o_ready;
        if (i_valid && o_ready) begin
            apply_request(i_item);
            n_acc <= n_acc + 1;
        end
    end

    always @(negedge i_clk) begin : drive
        int ph;
        int send_idle;
        int recv_idle;
        if (i_rst_n) begin
            ph = (n_items > 0) ? (n_acc * 3) / n_items : 2;
            case (ph)
                0: begin
                    send_idle = 10;
                    recv_idle = 88;
                end
                1: begin
                    send_idle = 88;
                    recv_idle = 10;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            if (!i_valid || in_taken) begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                    i_item <= request_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int alloc_pct;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_item = '0;
        in_taken = 1'b0;
        n_acc = 0;
        n_err = 0;
        n_items = 0;
        for (int w = 0; w < MAP_WORDS; w++) begin
            free_words[w] = '1;
        end

        // lowest-first order, reuse of a freed id, ignored and redundant releases
        queue_alloc();
        queue_alloc();
        queue_alloc();
        queue_release(32'd2);
        queue_release(32'd2);
        queue_alloc();
        queue_release(32'd0);
        queue_release(CAPACITY + 1);
        queue_release(32'hffff_ffff);
        queue_release(CAPACITY);
        queue_release(32'h8000_0001);
        queue_release(32'h7fff_fffe);
        queue_alloc();
        queue_release(32'd1);
        queue_alloc();
        queue_release(32'd3);
        queue_release(32'd4);
        queue_alloc();
        queue_alloc();
        queue_release(32'd32);
        queue_release(32'd33);
        queue_alloc();

        // fill until the map is full, then churn with mixed traffic
        for (int i = 0; i < N_RANDOM; i++) begin
            alloc_pct = (i < N_FILL) ? 98 : 45;
            if ($urandom_range(0, 99) < alloc_pct) begin
                queue_alloc();
            end else begin
                queue_release(pick_release_id());
            end
        end
        n_items = request_q.size();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_acc != n_items) @(posedge i_clk);
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (n_err == 0 && grant_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/bia_pkg.sv
rtl/bia_ram.sv
rtl/bia_ctrl.sv
rtl/bia_dp.sv
rtl/bitmap_id_allocator_core.sv
rtl/bia_checker.sv
dv/tb_bitmap_id_allocator_core.sv
